>>> sv/brt_pkg.sv
package brt_pkg;

  // table geometry
  localparam int unsigned Entries = 64;
  localparam int unsigned IdxW    = $clog2(Entries);
  localparam int unsigned CntW    = $clog2(Entries + 1);

  // paths below this health are never chosen
  localparam logic signed [15:0] HealthFloor = -16'sd10000;

  // command codes
  localparam logic CmdUpdate = 1'b0;
  localparam logic CmdLookup = 1'b1;

  // update status codes
  localparam logic [1:0] StatusRefresh = 2'd0;
  localparam logic [1:0] StatusInsert  = 2'd1;
  localparam logic [1:0] StatusDrop    = 2'd2;

  // input word
  typedef struct packed {
    logic               cmd;
    logic [31:0]        gateway_address;
    logic [31:0]        node_address;
    logic [63:0]        advert_stamp;
    logic signed [15:0] health_in;
  } in_word_t;

  // result word
  typedef struct packed {
    logic               found;
    logic [31:0]        best_gateway;
    logic [31:0]        best_node;
    logic [63:0]        best_stamp;
    logic signed [15:0] best_health;
    logic [1:0]         update_status;
  } out_word_t;

  // one stored path
  typedef struct packed {
    logic [31:0]        node;
    logic [31:0]        gateway;
    logic [63:0]        stamp;
    logic signed [15:0] health;
  } entry_t;

  // table ram access for one cycle
  typedef struct packed {
    logic            wr_en;
    logic [IdxW-1:0] wr_addr;
    entry_t          wr_data;
    logic            rd_en;
    logic [IdxW-1:0] rd_addr;
  } ram_req_t;

endpackage

>>> sv/brt_ram.sv
module brt_ram (
  input  logic              clk_i,
  input  brt_pkg::ram_req_t req_i,
  output brt_pkg::entry_t   rd_data_o
);

  brt_pkg::entry_t mem_q [brt_pkg::Entries];
  brt_pkg::entry_t rd_data_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem_q[req_i.rd_addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> sv/brt_ctrl.sv
module brt_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  brt_pkg::in_word_t  in_word_i,
  output logic               in_stall_o,
  input  logic               res_ready_i,
  output logic               res_valid_o,
  output brt_pkg::out_word_t res_word_o,
  output brt_pkg::ram_req_t  ram_req_o,
  input  brt_pkg::entry_t    ram_rd_data_i
);

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StScan   = 2'd1;
  localparam logic [1:0] StFinish = 2'd2;

  logic [1:0]                  state_q, state_d;
  logic [brt_pkg::CntW-1:0]    count_q, count_d;
  logic [brt_pkg::CntW-1:0]    rd_idx_q, rd_idx_d;
  logic                        rd_pend_q, rd_pend_d;
  logic [brt_pkg::IdxW-1:0]    rd_slot_q, rd_slot_d;
  logic                        hit_q, hit_d;
  logic                        chosen_q, chosen_d;
  logic signed [15:0]          best_health_q, best_health_d;
  brt_pkg::entry_t             best_q, best_d;
  brt_pkg::in_word_t           item_q, item_d;
  logic                        node_match;
  logic                        gw_match;
  logic                        table_full;

  assign node_match = rd_pend_q && (ram_rd_data_i.node == item_q.node_address);
  assign gw_match   = ram_rd_data_i.gateway == item_q.gateway_address;
  assign table_full = count_q >= brt_pkg::CntW'(brt_pkg::Entries);
  assign in_stall_o = state_q != StIdle;

  // scan sequencer: read each filled slot in turn, compare on return
  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    rd_idx_d      = rd_idx_q;
    rd_pend_d     = 1'b0;
    rd_slot_d     = rd_slot_q;
    hit_d         = hit_q;
    chosen_d      = chosen_q;
    best_health_d = best_health_q;
    best_d        = best_q;
    item_d        = item_q;
    ram_req_o     = '0;
    res_valid_o   = 1'b0;
    res_word_o    = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          item_d        = in_word_i;
          rd_idx_d      = '0;
          hit_d         = 1'b0;
          chosen_d      = 1'b0;
          best_health_d = brt_pkg::HealthFloor;
          state_d       = StScan;
        end
      end
      StScan: begin
        // issue the next read
        if (rd_idx_q < count_q) begin
          ram_req_o.rd_en   = 1'b1;
          ram_req_o.rd_addr = rd_idx_q[brt_pkg::IdxW-1:0];
          rd_idx_d          = rd_idx_q + 1'b1;
          rd_pend_d         = 1'b1;
          rd_slot_d         = rd_idx_q[brt_pkg::IdxW-1:0];
        end else if (!rd_pend_q) begin
          state_d = StFinish;
        end
        // compare returned entry, write back a refreshed path
        if (node_match) begin
          if (item_q.cmd == brt_pkg::CmdUpdate) begin
            if (gw_match) begin
              hit_d                    = 1'b1;
              ram_req_o.wr_en          = 1'b1;
              ram_req_o.wr_addr        = rd_slot_q;
              ram_req_o.wr_data        = ram_rd_data_i;
              ram_req_o.wr_data.stamp  = item_q.advert_stamp;
              ram_req_o.wr_data.health = item_q.health_in;
            end
          end else if (ram_rd_data_i.health >= best_health_q) begin
            // later entry wins on a tie
            chosen_d      = 1'b1;
            best_health_d = ram_rd_data_i.health;
            best_d        = ram_rd_data_i;
          end
        end
      end
      StFinish: begin
        res_valid_o = 1'b1;
        if (item_q.cmd == brt_pkg::CmdUpdate) begin
          if (hit_q) begin
            res_word_o.update_status = brt_pkg::StatusRefresh;
          end else if (table_full) begin
            res_word_o.update_status = brt_pkg::StatusDrop;
          end else begin
            res_word_o.update_status = brt_pkg::StatusInsert;
          end
        end else if (chosen_q && (best_q.node != '0)) begin
          res_word_o.found        = 1'b1;
          res_word_o.best_gateway = best_q.gateway;
          res_word_o.best_node    = best_q.node;
          res_word_o.best_stamp   = best_q.stamp;
          res_word_o.best_health  = best_q.health;
        end
        // append the new path once the result is taken
        if (res_ready_i) begin
          state_d = StIdle;
          if (item_q.cmd == brt_pkg::CmdUpdate && !hit_q && !table_full) begin
            ram_req_o.wr_en           = 1'b1;
            ram_req_o.wr_addr         = count_q[brt_pkg::IdxW-1:0];
            ram_req_o.wr_data.node    = item_q.node_address;
            ram_req_o.wr_data.gateway = item_q.gateway_address;
            ram_req_o.wr_data.stamp   = item_q.advert_stamp;
            ram_req_o.wr_data.health  = item_q.health_in;
            count_d                   = count_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      count_q       <= '0;
      rd_idx_q      <= '0;
      rd_pend_q     <= 1'b0;
      hit_q         <= 1'b0;
      chosen_q      <= 1'b0;
      best_health_q <= brt_pkg::HealthFloor;
    end else begin
      state_q       <= state_d;
      count_q       <= count_d;
      rd_idx_q      <= rd_idx_d;
      rd_pend_q     <= rd_pend_d;
      hit_q         <= hit_d;
      chosen_q      <= chosen_d;
      best_health_q <= best_health_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    item_q    <= item_d;
    best_q    <= best_d;
    rd_slot_q <= rd_slot_d;
  end

endmodule

>>> sv/best_path_route_table_unit.sv
// Route table of paths to nodes, keyed by node and gateway address.
// Input channel (in_valid_i, in_stall_o, in_word_i): a word with cmd update
// refreshes stamp and health of a matching path, else appends one if not full;
// a word with cmd lookup returns the healthiest usable path for the node.
// Output channel (out_valid_o, out_stall_i, out_word_o): one result word per
// input word, in order.
// Each word scans the filled slots of a single-port-read table ram, one slot
// a cycle through its registered read port, up to 64 slots; only one word
// is in work at a time, as the input stays stalled from acceptance until the
// result is handed to the output register.
// The result sits in an output register: the next word is taken while the
// result waits. If the receiver stalls and a second result is ready, the
// block holds that result and stalls its input until the register frees.
// Reset empties the table (fill count to zero) and drops any word in work;
// the ram contents are not cleared, as only filled slots are ever read.
module best_path_route_table_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  brt_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output brt_pkg::out_word_t out_word_o
);

  logic               res_valid;
  logic               res_ready;
  brt_pkg::out_word_t res_word;
  brt_pkg::ram_req_t  ram_req;
  brt_pkg::entry_t    ram_rd_data;
  logic               out_valid_q, out_valid_d;
  brt_pkg::out_word_t out_word_q;

  brt_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_word_i     (in_word_i),
    .in_stall_o    (in_stall_o),
    .res_ready_i   (res_ready),
    .res_valid_o   (res_valid),
    .res_word_o    (res_word),
    .ram_req_o     (ram_req),
    .ram_rd_data_i (ram_rd_data)
  );

  brt_ram u_ram (
    .clk_i     (clk_i),
    .req_i     (ram_req),
    .rd_data_o (ram_rd_data)
  );

  // output register
  assign res_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_word_q <= res_word;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // a found path always carries a nonzero node and no update status
  a_found_word : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.found |->
      (out_word_o.best_node != '0) && (out_word_o.update_status == brt_pkg::StatusRefresh))
    else $error("found result with zero node or update status");

  // a write back never lands on the slot being read in the same cycle
  a_ram_no_overlap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_req.wr_en && ram_req.rd_en |-> ram_req.wr_addr != ram_req.rd_addr)
    else $error("table ram read and write to the same slot");

  // while a result is pending the input stays stalled
  a_busy_on_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> in_stall_o)
    else $error("input accepted while a result is pending");

  // a result held in the register by a stall is not replaced
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("stalled result changed");

endmodule
